[hw/rtl/tga_pkg.sv]
// Shared types and constants for the TGA run-length stream decoder.
package tga_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_CMAP     = 2'd2;
    localparam logic [1:0] ST_BAD_BPP  = 2'd3;

    localparam logic [7:0] KIND_RGB  = 8'd2;
    localparam logic [7:0] KIND_GRAY = 8'd3;
    localparam logic [7:0] KIND_RLE  = 8'd10;

    localparam int QueueDepth = 4;

    // Classified event handed from the front end to the run engine
    typedef struct packed {
        logic        init;      // new image geometry: reset counters
        logic        result;    // emit a run
        logic        fixed;     // fixed result (error or empty image)
        logic [1:0]  status;
        logic [31:0] rgba;      // {a, r, g, b}
        logic [7:0]  len;       // requested run length (before clipping)
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  flip;
    } job_t;

endpackage

[hw/rtl/tga_front.sv]
// Front end: header parse, ID skip, packet and pixel byte assembly.
module tga_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    data_byte,
    input  logic          start_of_file,
    output logic          job_valid,
    output tga_pkg::job_t job
);
    import tga_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hcnt_reg, hcnt_next;
    logic [7:0]  idskip_reg, idskip_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  cmap_reg, cmap_next;
    logic [7:0]  bpp_reg, bpp_next;
    logic [1:0]  flip_reg, flip_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] h_reg, h_next;
    logic [7:0]  pleft_reg, pleft_next;
    logic        prep_reg, prep_next;
    logic [23:0] pix_reg, pix_next;
    logic [1:0]  pidx_reg, pidx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcnt_reg   <= '0;
            idskip_reg <= '0;
            kind_reg   <= '0;
            cmap_reg   <= '0;
            bpp_reg    <= '0;
            flip_reg   <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            pleft_reg  <= '0;
            prep_reg   <= 1'b0;
            pix_reg    <= '0;
            pidx_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            idskip_reg <= idskip_next;
            kind_reg   <= kind_next;
            cmap_reg   <= cmap_next;
            bpp_reg    <= bpp_next;
            flip_reg   <= flip_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            pleft_reg  <= pleft_next;
            prep_reg   <= prep_next;
            pix_reg    <= pix_next;
            pidx_reg   <= pidx_next;
        end
    end

    // Parse state machine
    always_comb
    begin
        phase_t      ph;
        logic [4:0]  hc;
        logic [7:0]  ids, knd, cmp, bpp;
        logic [1:0]  flp;
        logic [15:0] wd, ht;
        logic [1:0]  st;
        logic [1:0]  last_idx;
        logic [7:0]  a_byte;

        ph  = phase_reg;
        hc  = hcnt_reg;
        ids = idskip_reg;
        knd = kind_reg;
        cmp = cmap_reg;
        bpp = bpp_reg;
        flp = flip_reg;
        wd  = w_reg;
        ht  = h_reg;
        st  = ST_OK;
        last_idx = 2'd0;
        a_byte = 8'hff;
        if (start_of_file)
        begin
            ph = PH_HEADER; hc = '0; ids = '0; knd = '0; cmp = '0; bpp = '0;
            flp = '0; wd = '0; ht = '0;
        end

        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        idskip_next = idskip_reg;
        kind_next   = kind_reg;
        cmap_next   = cmap_reg;
        bpp_next    = bpp_reg;
        flip_next   = flip_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        pleft_next  = pleft_reg;
        prep_next   = prep_reg;
        pix_next    = pix_reg;
        pidx_next   = pidx_reg;
        job_valid   = 1'b0;
        job         = '0;

        if (in_fire)
        begin
            phase_next = ph; hcnt_next = hc; idskip_next = ids; kind_next = knd;
            cmap_next = cmp; bpp_next = bpp; flip_next = flp; w_next = wd; h_next = ht;
            if (start_of_file)
            begin
                pleft_next = '0; prep_next = 1'b0; pix_next = '0; pidx_next = '0;
            end
            unique case (ph)
                PH_HEADER:
                begin
                    case (hc)
                        5'd0:  idskip_next = data_byte;
                        5'd1:  cmap_next = data_byte;
                        5'd2:  kind_next = data_byte;
                        5'd12: w_next = {wd[15:8], data_byte};
                        5'd13: w_next = {data_byte, wd[7:0]};
                        5'd14: h_next = {ht[15:8], data_byte};
                        5'd15: h_next = {data_byte, ht[7:0]};
                        5'd16: bpp_next = data_byte;
                        5'd17: flip_next = {data_byte[5], data_byte[4]};
                        default: ;
                    endcase
                    hcnt_next = (hc == 5'd31) ? hc : hc + 5'd1;
                    if (hc >= 5'd17)
                    begin
                        if (knd != KIND_RGB && knd != KIND_GRAY && knd != KIND_RLE)
                            st = ST_BAD_TYPE;
                        else if (cmp != 8'd0)
                            st = ST_CMAP;
                        else if ((bpp_next != 8'd8 && bpp_next != 8'd24 &&
                                  bpp_next != 8'd32) ||
                                 (bpp_next == 8'd8 && knd != KIND_GRAY))
                            st = ST_BAD_BPP;
                        job.width  = w_next;
                        job.height = h_next;
                        job.flip   = flip_next;
                        job_valid  = 1'b1;
                        if (st != ST_OK || w_next == 16'd0 || h_next == 16'd0)
                        begin
                            job.result = 1'b1;
                            job.fixed  = 1'b1;
                            job.status = st;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            job.init   = 1'b1;
                            pleft_next = '0;
                            prep_next  = 1'b0;
                            pix_next   = '0;
                            pidx_next  = '0;
                            if (ids != 8'd0)
                                phase_next = PH_IDSKIP;
                            else
                                phase_next = (knd == KIND_RLE) ? PH_PACKET : PH_PIXEL;
                        end
                    end
                end
                PH_IDSKIP:
                begin
                    idskip_next = ids - 8'd1;
                    if (ids <= 8'd1)
                    begin
                        idskip_next = '0;
                        phase_next = (knd == KIND_RLE) ? PH_PACKET : PH_PIXEL;
                    end
                end
                PH_PACKET:
                begin
                    prep_next  = data_byte[7];
                    pleft_next = {1'b0, data_byte[6:0]} + 8'd1;
                    pix_next   = '0;
                    pidx_next  = '0;
                    phase_next = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    last_idx = (bpp == 8'd8) ? 2'd0 : (bpp == 8'd24) ? 2'd2 : 2'd3;
                    if (pidx_reg == last_idx)
                    begin
                        job_valid = 1'b1;
                        job.result = 1'b1;
                        if (bpp == 8'd8)
                            job.rgba = {8'hff, data_byte, data_byte, data_byte};
                        else
                        begin
                            a_byte = (bpp == 8'd32) ? data_byte : 8'hff;
                            if (bpp == 8'd32)
                                job.rgba = {a_byte, pix_reg[23:16], pix_reg[15:8],
                                            pix_reg[7:0]};
                            else
                                job.rgba = {a_byte, data_byte, pix_reg[15:8],
                                            pix_reg[7:0]};
                        end
                        if (knd == KIND_RLE && prep_reg)
                        begin
                            job.len = pleft_reg;
                            pleft_next = '0;
                        end
                        else
                        begin
                            job.len = 8'd1;
                            if (pleft_reg != 8'd0)
                                pleft_next = pleft_reg - 8'd1;
                        end
                        pix_next  = '0;
                        pidx_next = '0;
                        if (knd == KIND_RLE && pleft_next == 8'd0)
                            phase_next = PH_PACKET;
                        else
                            phase_next = PH_PIXEL;
                    end
                    else
                    begin
                        case (pidx_reg)
                            2'd0: pix_next[7:0]   = data_byte;
                            2'd1: pix_next[15:8]  = data_byte;
                            default: pix_next[23:16] = data_byte;
                        endcase
                        pidx_next = pidx_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/tga_queue.sv]
// Small FIFO of classified jobs between front end and run engine.
module tga_queue
#(
    parameter int Depth = tga_pkg::QueueDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tga_pkg::job_t wr_data,
    input  logic          rd_en,
    output logic          rd_valid,
    output tga_pkg::job_t rd_data,
    output logic          almost_full
);
    import tga_pkg::*;

    localparam int AW = $clog2(Depth);

    job_t        mem [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + AW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    assign rd_valid    = (cnt_reg != '0);
    assign rd_data     = mem[rp_reg];
    assign almost_full = (cnt_reg >= (AW+1)'(Depth-1));

endmodule

[hw/rtl/tga_back.sv]
// Run engine: clips runs, maps to destination row/column, advances position.
module tga_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  tga_pkg::job_t job,
    output logic          job_take,
    output logic          valid,
    input  logic          stall,
    output logic [1:0]    status,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue,
    output logic [7:0]    alpha,
    output logic [15:0]   first_row,
    output logic [15:0]   first_col,
    output logic [7:0]    run_length,
    output logic          last
);
    import tga_pkg::*;

    logic [15:0] w_reg, h_reg, row_reg, col_reg;
    logic [31:0] rem_reg;
    logic [1:0]  flip_reg;
    logic        done_reg;
    logic        ov_reg;
    logic        busy_reg;
    logic [16:0] acc_reg;
    logic [2:0]  k_reg;
    logic [1:0]  st_reg;
    logic [31:0] rgba_reg;
    logic [15:0] orow_reg, ocol_reg;
    logic [7:0]  olen_reg;
    logic        olast_reg;

    logic        out_free;
    logic        emit;
    logic [7:0]  len;
    logic        is_last;
    logic [16:0] ncol;
    logic [16:0] nsub;
    logic [16:0] wk;
    logic [16:0] acc_sub;
    logic        acc_ge;

    assign out_free = !ov_reg || !stall;
    assign job_take = job_valid && !busy_reg && (out_free || !job.result);
    assign emit     = job_take && job.result && (job.fixed || !done_reg);

    // Clip the run to the pixels left in the image; next column before wrapping
    always_comb
    begin
        len = job.len;
        if ({24'd0, job.len} > rem_reg)
            len = rem_reg[7:0];
        is_last = ({24'd0, len} == rem_reg);
        ncol    = {1'b0, col_reg} + {9'd0, len};
        nsub    = ncol - {1'b0, w_reg};
    end

    // Row wrap of a narrow image: one quotient bit per cycle
    assign wk      = {1'b0, w_reg} << k_reg;
    assign acc_ge  = (acc_reg >= wk);
    assign acc_sub = acc_reg - wk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= '0;
            h_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            rem_reg  <= '0;
            flip_reg <= '0;
            done_reg <= 1'b0;
            ov_reg   <= 1'b0;
            busy_reg <= 1'b0;
            acc_reg  <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (!stall)
                ov_reg <= 1'b0;

            if (busy_reg)
            begin
                if (acc_ge)
                begin
                    acc_reg <= acc_sub;
                    row_reg <= row_reg + (16'd1 << k_reg);
                end
                if (k_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    col_reg  <= acc_ge ? acc_sub[15:0] : acc_reg[15:0];
                end
                k_reg <= k_reg - 3'd1;
            end
            else if (job_take)
            begin
                if (job.init)
                begin
                    w_reg    <= job.width;
                    h_reg    <= job.height;
                    flip_reg <= job.flip;
                    row_reg  <= '0;
                    col_reg  <= '0;
                    rem_reg  <= {16'd0, job.width} * {16'd0, job.height};
                    done_reg <= 1'b0;
                end
                else if (job.result && job.fixed)
                    done_reg <= 1'b1;
                else if (job.result && !done_reg)
                begin
                    rem_reg <= rem_reg - {24'd0, len};
                    if (is_last)
                        done_reg <= 1'b1;
                    // no wrap, a single wrap, or several wraps (width under 128)
                    if (ncol < {1'b0, w_reg})
                        col_reg <= ncol[15:0];
                    else if (nsub < {1'b0, w_reg})
                    begin
                        col_reg <= nsub[15:0];
                        row_reg <= row_reg + 16'd1;
                    end
                    else
                    begin
                        busy_reg <= 1'b1;
                        acc_reg  <= ncol;
                        k_reg    <= 3'd7;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (job.fixed)
            begin
                st_reg    <= job.status;
                rgba_reg  <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
                olen_reg  <= '0;
                olast_reg <= 1'b1;
            end
            else
            begin
                st_reg    <= ST_OK;
                rgba_reg  <= job.rgba;
                orow_reg  <= flip_reg[1] ? row_reg : h_reg - 16'd1 - row_reg;
                ocol_reg  <= flip_reg[0] ? w_reg - 16'd1 - col_reg : col_reg;
                olen_reg  <= len;
                olast_reg <= is_last;
            end
        end
    end

    assign valid      = ov_reg;
    assign status     = st_reg;
    assign alpha      = rgba_reg[31:24];
    assign red        = rgba_reg[23:16];
    assign green      = rgba_reg[15:8];
    assign blue       = rgba_reg[7:0];
    assign first_row  = orow_reg;
    assign first_col  = ocol_reg;
    assign run_length = olen_reg;
    assign last       = olast_reg;

endmodule

[hw/rtl/tga_rle_stream_decoder.sv]
// Top level of the TGA run-length stream decoder.
// Usage:
//   Input channel: data_byte/start_of_file with in_valid/in_stall, one file
//   byte per word. start_of_file marks header byte zero and restarts parsing.
//   Output channel: one run word per valid/stall handshake: status, RGBA,
//   destination row/column of the first pixel, run_length and last.
// Path: with the run engine free, the job for a byte that completes a pixel
//   passes through the job queue, then the run engine output register, which
//   raises valid.
// Throughput: one byte per cycle while in_stall is low; the run engine
//   takes no new run while one wraps more than one row (images under 128 wide).
//   in_stall rises when the job queue holds one less than its depth (three),
//   which happens when the receiver stalls the output or runs wrap rows.
// Reset: all parse and position state clears; the first byte after reset is
//   header byte zero. Runs of an old file still queued at start_of_file are
//   delivered before those of the new one.
// Receiver stall: the output word holds; the queue absorbs a few runs, then
//   in_stall is raised. Errors and empty images give one word with last set;
//   later bytes are ignored until start_of_file.
module tga_rle_stream_decoder
#(
    parameter int QDepth = tga_pkg::QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        valid,
    input  logic        stall,
    output logic [1:0]  status,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [15:0] first_row,
    output logic [15:0] first_col,
    output logic [7:0]  run_length,
    output logic        last
);
    import tga_pkg::*;

    logic  in_fire, fjob_valid, q_valid, q_take, q_af;
    job_t  fjob, qjob;

    assign in_stall = q_af;
    assign in_fire  = in_valid && !in_stall;

    tga_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .data_byte(data_byte),
        .start_of_file(start_of_file),
        .job_valid(fjob_valid), .job(fjob)
    );

    tga_queue #(.Depth(QDepth)) u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr_en(fjob_valid),
        .wr_data(fjob), .rd_en(q_take), .rd_valid(q_valid),
        .rd_data(qjob), .almost_full(q_af)
    );

    tga_back u_back
    (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(qjob),
        .job_take(q_take), .valid(valid), .stall(stall),
        .status(status), .red(red), .green(green), .blue(blue), .alpha(alpha),
        .first_row(first_row), .first_col(first_col), .run_length(run_length),
        .last(last)
    );

endmodule

[hw/rtl/tga_checker.sv]
// Port-level checker for the TGA decoder, bound to the top level.
module tga_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        stall,
    input logic [1:0]  status,
    input logic [7:0]  run_length,
    input logic        last
);
    import tga_pkg::*;

    // A stalled run word holds (valid, run_length and last are checked)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && stall |=> valid && $stable(run_length) && $stable(last))
        else $error("output word changed under stall");

    // Error words are final and empty
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_OK |-> last && run_length == 8'd0)
        else $error("error word malformed");

    // Run length never exceeds one packet
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> run_length <= 8'd128)
        else $error("run too long");

endmodule

bind tga_rle_stream_decoder tga_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall), .status(status),
    .run_length(run_length), .last(last)
);
